>>> hdl/nkt_pkg.sv
// ----------------------------------------------------------------------------
// nkt_pkg
// Types and constants shared by the nearest-key table: item layouts, the
// stored entry layout and the result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package nkt_pkg;

  // Table depth default and fixed field widths
  localparam int unsigned TableDepthDefault = 16;
  localparam int unsigned KeyBits           = 32;
  localparam int unsigned ValueBits         = 8;
  localparam int unsigned StatusBits        = 3;

  // Command codes
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  // Result status codes
  typedef enum logic [StatusBits-1:0] {
    ST_FOUND    = 3'd0,
    ST_INSERTED = 3'd1,
    ST_EXISTED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  // Input item
  typedef struct packed {
    logic                        command;
    logic signed [KeyBits-1:0]   key;
    logic        [ValueBits-1:0] new_value;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic        [StatusBits-1:0] status;
    logic        [ValueBits-1:0]  found_value;
    logic signed [KeyBits-1:0]    nearest_key;
  } out_item_t;

  // One stored table entry
  typedef struct packed {
    logic signed [KeyBits-1:0]   key;
    logic        [ValueBits-1:0] value;
  } entry_t;

endpackage

`default_nettype wire

>>> hdl/nearest_key_table.sv
// ----------------------------------------------------------------------------
// nearest_key_table
// Sorted table of unique signed keys with a value each. Inserts keep the
// table in ascending order; lookups return the nearest stored key.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+--------------------------
//  in      | input     | in_valid_i / in_ready_o | in_item_i  (in_item_t)
//  out     | output    | out_valid_o / out_ready_i | out_item_o (out_item_t)
//
//  A lookup scans the stored entries up to the first key above the asked key;
//  an insert adds a shift of the entries above the insert point, so the scan
//  and the insert shift cover the table once between them. The single read
//  port of the entry memory makes both serial: the scan reads one entry a
//  cycle, and the insert shift moves one entry a cycle.
//  Reset empties the table at once (fill count only, no clearing pass).
//  A new item is taken while the previous result waits on a stalled output;
//  that item's result waits in the sequencer until the output register frees.
//
`default_nettype none

module nearest_key_table
  import nkt_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDefault
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  wire       out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CW = $clog2(TableDepth + 1);
  localparam logic [CW-1:0] DepthC = CW'(TableDepth);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] wr_idx_q, wr_idx_d;
  in_item_t      item_q, item_d;
  entry_t        prev_q, prev_d;
  entry_t        next_q, next_d;
  out_item_t     res_q, res_d;
  out_item_t     out_q, out_d;
  logic          out_valid_q, out_valid_d;

  // Entry memory, one write and one registered read port
  entry_t        mem_q [TableDepth];
  entry_t        mem_rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_wdata;

  // Nearest pick: next + prev < 2k means the upper neighbor is strictly closer
  logic signed [KeyBits+1:0] pair_sum;
  logic signed [KeyBits+1:0] twice_key;
  logic                      pick_up;

  assign pair_sum  = {{2{next_q.key[KeyBits-1]}}, next_q.key}
                   + {{2{prev_q.key[KeyBits-1]}}, prev_q.key};
  assign twice_key = {item_q.key[KeyBits-1], item_q.key, 1'b0};
  assign pick_up   = pair_sum < twice_key;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    wr_idx_d    = wr_idx_q;
    item_d      = item_q;
    prev_d      = prev_q;
    next_d      = next_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d    = in_item_i;
          idx_d     = '0;
          mem_raddr = '0;
          state_d   = S_SCAN;
        end
      end

      // rdata holds entry idx; find the first key above the asked key
      S_SCAN: begin
        if (idx_q == count_q) begin
          state_d = S_DECIDE;
        end else if (mem_rdata_q.key <= item_q.key) begin
          prev_d    = mem_rdata_q;
          idx_d     = idx_q + CW'(1);
          mem_raddr = AW'(idx_q + CW'(1));
        end else begin
          next_d  = mem_rdata_q;
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        res_d = '0;
        if (item_q.command == CMD_INSERT) begin
          if ((idx_q != '0) && (prev_q.key == item_q.key)) begin
            res_d.status = ST_EXISTED;
            state_d      = S_DONE;
          end else if (count_q == DepthC) begin
            res_d.status = ST_FULL;
            state_d      = S_DONE;
          end else begin
            wr_idx_d  = count_q;
            mem_raddr = AW'(count_q - CW'(1));
            state_d   = S_SHIFT;
          end
        end else begin
          state_d = S_DONE;
          if (count_q == '0) begin
            res_d.status = ST_EMPTY;
          end else begin
            res_d.status = ST_FOUND;
            if ((idx_q == '0) || ((idx_q != count_q) && pick_up)) begin
              res_d.found_value = next_q.value;
              res_d.nearest_key = next_q.key;
            end else begin
              res_d.found_value = prev_q.value;
              res_d.nearest_key = prev_q.key;
            end
          end
        end
      end

      // Move entries up by one from the top down, then drop the new one in
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(wr_idx_q);
        if (wr_idx_q == idx_q) begin
          mem_wdata.key   = item_q.key;
          mem_wdata.value = item_q.new_value;
          count_d         = count_q + CW'(1);
          res_d           = '0;
          res_d.status    = ST_INSERTED;
          state_d         = S_DONE;
        end else begin
          mem_wdata = mem_rdata_q;
          wr_idx_d  = wr_idx_q - CW'(1);
          mem_raddr = AW'(wr_idx_q - CW'(2));
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    wr_idx_q <= wr_idx_d;
    item_q   <= item_d;
    prev_q   <= prev_d;
    next_q   <= next_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  // Entry memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  // Fill count never passes the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count above table depth");

  // Fill count only ever grows by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CW'(1)))
    else $error("entry count changed by other than one");

  // Scan never runs past the filled part of the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q <= count_q))
    else $error("scan index beyond entry count");

  // Shift stays within the table and above the insert slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> ((wr_idx_q >= idx_q) && (count_q < DepthC)))
    else $error("insert shift out of range");

endmodule

`default_nettype wire

>>> tb/nkt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nkt_checker
// Watches both channels of the nearest-key table. It keeps its own sorted
// copy of the table, works out the result of every accepted input item and
// compares each accepted result, field by field, with the oldest one waiting.
// ----------------------------------------------------------------------------

module nkt_checker
  import nkt_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDefault
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  input  wire       in_ready_i,
  input  in_item_t  in_item_i,
  input  wire       out_valid_i,
  input  wire       out_ready_i,
  input  out_item_t out_item_i,
  output int        mismatch_cnt_o,
  output int        pending_o
);

  // Shadow table, kept in ascending key order
  logic signed [KeyBits-1:0]   shadow_key [TableDepth];
  logic        [ValueBits-1:0] shadow_val [TableDepth];
  int unsigned                 shadow_fill;

  out_item_t expected_results_q[$];

  initial mismatch_cnt_o = 0;
  initial pending_o      = 0;

  // Apply one item to the shadow table and return the result it causes
  function automatic out_item_t apply_item(in_item_t item);
    int unsigned             above;
    int unsigned             pick;
    int unsigned             i;
    logic signed [KeyBits:0] dist_up;
    logic signed [KeyBits:0] dist_lo;
    out_item_t               res;
    res   = '0;
    above = 0;
    // first stored key strictly greater than the item key
    while (above < shadow_fill && shadow_key[above] <= item.key) above++;
    if (item.command == CMD_INSERT) begin
      if (above > 0 && shadow_key[above-1] == item.key) begin
        res.status = ST_EXISTED;
      end else if (shadow_fill >= TableDepth) begin
        res.status = ST_FULL;
      end else begin
        // open a slot at the insert point
        for (i = shadow_fill; i > above; i--) begin
          shadow_key[i] = shadow_key[i-1];
          shadow_val[i] = shadow_val[i-1];
        end
        shadow_key[above] = item.key;
        shadow_val[above] = item.new_value;
        shadow_fill++;
        res.status = ST_INSERTED;
      end
    end else if (shadow_fill == 0) begin
      res.status = ST_EMPTY;
    end else begin
      if (above == 0) begin
        pick = 0;
      end else if (above >= shadow_fill) begin
        pick = shadow_fill - 1;
      end else begin
        // 33-bit distances, tie goes to the lower key
        dist_up = shadow_key[above] - item.key;
        dist_lo = item.key - shadow_key[above-1];
        pick    = (dist_up < dist_lo) ? above : above - 1;
      end
      res.status      = ST_FOUND;
      res.found_value = shadow_val[pick];
      res.nearest_key = shadow_key[pick];
    end
    return res;
  endfunction

  // Compare results first, then queue the prediction for a new item
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_res;
    if (!rst_ni) begin
      shadow_fill = 0;
      expected_results_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results_q.size() == 0) begin
          if (mismatch_cnt_o < 10)
            $display("%0t: result with none expected: status %0d value %0d key %0d",
                     $realtime, out_item_i.status, out_item_i.found_value,
                     out_item_i.nearest_key);
          mismatch_cnt_o++;
        end else begin
          exp_res = expected_results_q.pop_front();
          if (exp_res.status !== out_item_i.status ||
              exp_res.found_value !== out_item_i.found_value ||
              exp_res.nearest_key !== out_item_i.nearest_key) begin
            if (mismatch_cnt_o < 10)
              $display("%0t: mismatch: exp status %0d value %0d key %0d, got %0d %0d %0d",
                       $realtime, exp_res.status, exp_res.found_value,
                       exp_res.nearest_key, out_item_i.status,
                       out_item_i.found_value, out_item_i.nearest_key);
            mismatch_cnt_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_results_q.push_back(apply_item(in_item_i));
    end
    pending_o = expected_results_q.size();
  end

endmodule

>>> tb/tb_nearest_key_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_key_table
// Drives inserts and nearest-key lookups into the table: a directed part for
// the corner cases, then random items in three idling phases, with long
// receiver hold-offs to back the block up. The checker does the comparing.
// ----------------------------------------------------------------------------

module tb_nearest_key_table;
  import nkt_pkg::*;

  localparam int unsigned Depth       = 16;
  localparam int          RandomItems = 1620;
  localparam int          StallLimit  = 3000;
  localparam int          HoldCycles  = 300;
  localparam int          DrainCycles = 60;

  localparam logic signed [KeyBits-1:0] KeyMin = 32'sh8000_0000;
  localparam logic signed [KeyBits-1:0] KeyMax = 32'sh7FFF_FFFF;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      in_ready;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int send_idle = 0;
  int recv_idle = 0;
  int mismatches;
  int pending;
  int stall_cycles = 0;
  int results_taken = 0;
  int hold_left = 0;

  // keys offered for insert, used to aim lookups and duplicates
  logic signed [KeyBits-1:0] offered_keys[$];

  always #10 clk = ~clk;

  nearest_key_table #(
    .TableDepth (Depth)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  nkt_checker #(
    .TableDepth (Depth)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_item_i      (in_item),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_item_i     (out_item),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending)
  );

  // Result side: random stalls, plus a long hold-off at two result counts
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) results_taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready && (results_taken == 200 || results_taken == 900)) begin
        hold_left = HoldCycles;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("tb_nearest_key_table NOT OK");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Offer one item; valid stays up across back-to-back items
  task automatic send_item(input cmd_e cmd, input logic signed [KeyBits-1:0] key,
                           input logic [ValueBits-1:0] value);
    in_item_t item;
    item.command   = cmd;
    item.key       = key;
    item.new_value = value;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (cmd == CMD_INSERT && offered_keys.size() < Depth + 4) offered_keys.push_back(key);
  endtask

  // Random item aimed near keys already offered
  task automatic send_random();
    cmd_e                      cmd;
    logic signed [KeyBits-1:0] key;
    logic signed [KeyBits-1:0] key_a;
    logic signed [KeyBits-1:0] key_b;
    logic signed [KeyBits:0]   mid;
    cmd   = cmd_e'($urandom_range(1));
    key_a = offered_keys[$urandom_range(offered_keys.size() - 1)];
    key_b = offered_keys[$urandom_range(offered_keys.size() - 1)];
    mid   = key_a;
    mid   = (mid + key_b) >>> 1;
    if (cmd == CMD_INSERT) begin
      key = $urandom_range(1) ? key_a : $urandom;
    end else begin
      case ($urandom_range(3))
        0:       key = $urandom;
        1:       key = key_a;
        2:       key = key_a + $urandom_range(6) - 3;
        default: key = mid[KeyBits-1:0] + $urandom_range(2) - 1;
      endcase
    end
    send_item(cmd, key, ValueBits'($urandom));
  endtask

  initial begin
    send_idle = 33;
    recv_idle = 65;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, far-apart keys, ties, duplicates, extremes
    send_item(CMD_LOOKUP, 32'sd0, 8'hFF);
    send_item(CMD_INSERT, -32'sd1000000000, 8'h00);
    send_item(CMD_INSERT, 32'sd1500000000, 8'hFF);
    send_item(CMD_LOOKUP, KeyMin, 8'h00);              // below every key
    send_item(CMD_LOOKUP, KeyMax, 8'h00);              // above every key
    send_item(CMD_LOOKUP, 32'sd250000000, 8'h00);      // tie over a 33-bit gap
    send_item(CMD_LOOKUP, 32'sd250000001, 8'h00);
    send_item(CMD_INSERT, 32'sd1500000000, 8'h11);     // duplicate keeps value
    send_item(CMD_LOOKUP, 32'sd1500000000, 8'h00);
    send_item(CMD_INSERT, KeyMin, 8'hA5);
    send_item(CMD_INSERT, KeyMax, 8'h5A);
    send_item(CMD_INSERT, 32'sd0, 8'h3C);
    send_item(CMD_LOOKUP, KeyMin, 8'h00);
    send_item(CMD_LOOKUP, KeyMax, 8'h00);
    send_item(CMD_LOOKUP, -32'sd1, 8'h00);
    send_item(CMD_LOOKUP, 32'sd750000000, 8'h00);      // tie, lower key wins
    // fill the table, then insert past full
    repeat (Depth - 5) send_item(CMD_INSERT, $urandom, ValueBits'($urandom));
    send_item(CMD_INSERT, $urandom, ValueBits'($urandom));
    send_item(CMD_INSERT, 32'sd0, 8'h99);              // duplicate while full

    // Random: three idling phases
    repeat (RandomItems / 3) send_random();
    send_idle = 65;
    recv_idle = 33;
    repeat (RandomItems / 3) send_random();
    send_idle = 0;
    recv_idle = 0;
    repeat (RandomItems / 3) send_random();
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_nearest_key_table OK");
    end else begin
      $display("tb_nearest_key_table NOT OK");
    end
    $finish;
  end

endmodule
